>>> src/tog_pkg.sv
package tog_pkg;

	// configuration port geometry
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 13;

	// field widths
	localparam int unsigned PIXEL_W = 8;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned SUB_W   = 8;

	// column flag slots, one per tile column
	localparam int unsigned MAX_TILE_COLS = 4096;
	localparam int unsigned SLOT_W        = $clog2(MAX_TILE_COLS);

	// register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 8'd0,
		REG_IMAGE_HEIGHT = 8'd1,
		REG_TILE_WIDTH   = 8'd2,
		REG_TILE_HEIGHT  = 8'd3
	} cfg_reg_e;

	// limits after reset, stored as size minus one (640, 480, 16, 16)
	localparam logic [POS_W-1:0] IMG_W_M1_RST  = 12'd639;
	localparam logic [POS_W-1:0] IMG_H_M1_RST  = 12'd479;
	localparam logic [SUB_W-1:0] TILE_W_M1_RST = 8'd15;
	localparam logic [SUB_W-1:0] TILE_H_M1_RST = 8'd15;

	// clamped sizes minus one, as the scan logic uses them
	typedef struct packed {
		logic [POS_W-1:0] img_w_m1;
		logic [POS_W-1:0] img_h_m1;
		logic [SUB_W-1:0] tile_w_m1;
		logic [SUB_W-1:0] tile_h_m1;
	} tog_limits_t;

	// one tile verdict
	typedef struct packed {
		logic             last_tile;
		logic             passable;
		logic [POS_W-1:0] tile_row;
		logic [POS_W-1:0] tile_col;
	} tog_result_t;

endpackage

>>> src/tile_obstacle_grid.sv
// Tile obstacle grid: takes a greyscale map one pixel per beat in raster
// order and returns one verdict per tile of tile_width by tile_height pixels,
// issued on the beat of the tile's bottom-right pixel (cut at the image edge).
// A tile is passable only when it is whole and every pixel equals FREE_LEVEL;
// partial tiles at the right and bottom edges come out blocked, and tlast
// marks the image's final tile. The block sustains one pixel per clock while
// the tile stream is not stalled: each beat costs one read and at most one
// write of the per-column flag memory (MAX_TILE_COLS bits, a power of two),
// and a verdict is registered as its pixel is taken. Each tile reloads
// its own flag, so the memory needs no clearing after reset. Any configuration
// write restarts the image at its top-left pixel; write only while idle.
module tile_obstacle_grid import tog_pkg::*; #(
	parameter int unsigned FREE_LEVEL    = 255
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// pixel stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] pixel
	// tile stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,   // [11:0] tile_col, [23:12] tile_row, [24] passable
	output logic                   m_tlast    // last_tile
);

	tog_limits_t lim;
	tog_result_t res;
	tog_result_t out_q;
	logic        out_valid_q;
	logic        hit;
	logic        accept;

	tog_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.lim    (lim)
	);

	// take a beat whenever the output register is free or draining
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	tog_scan #(
		.FREE_LEVEL    (FREE_LEVEL)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.lim     (lim),
		.restart (cfg_we),
		.accept  (accept),
		.pixel   (s_tdata),
		.hit     (hit),
		.res     (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= hit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept && hit)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.passable, out_q.tile_row, out_q.tile_col};
	assign m_tlast  = out_q.last_tile;

`ifndef NO_ASSERTIONS
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while output stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending verdict lost");

	a_verdict_follows_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit) |=> out_valid_q)
		else $error("verdict not registered");
`endif

endmodule

>>> src/tog_cfg.sv
module tog_cfg import tog_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   we,
	input  logic [CFG_INDEX_W-1:0] index,
	input  logic [CFG_DATA_W-1:0]  data,
	output tog_limits_t            lim
);

	tog_limits_t lim_q;

	// zero acts as one, image sizes cap at 4096
	function automatic logic [POS_W-1:0] img_m1(input logic [CFG_DATA_W-1:0] v);
		logic [CFG_DATA_W-1:0] dec;
		dec = v - 13'd1;
		if (v == 13'd0)
			return '0;
		else if (v > 13'd4096)
			return '1;
		else
			return dec[POS_W-1:0];
	endfunction

	// only the low nine bits count; zero acts as one, tile sizes cap at 256
	function automatic logic [SUB_W-1:0] tile_m1(input logic [CFG_DATA_W-1:0] v);
		logic [8:0] t;
		logic [8:0] dec;
		t   = v[8:0];
		dec = t - 9'd1;
		if (t == 9'd0)
			return '0;
		else if (t > 9'd256)
			return '1;
		else
			return dec[SUB_W-1:0];
	endfunction

	// store the clamped limits on each write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.img_w_m1  <= IMG_W_M1_RST;
			lim_q.img_h_m1  <= IMG_H_M1_RST;
			lim_q.tile_w_m1 <= TILE_W_M1_RST;
			lim_q.tile_h_m1 <= TILE_H_M1_RST;
		end else if (we) begin
			unique case (index)
				REG_IMAGE_WIDTH:  lim_q.img_w_m1  <= img_m1(data);
				REG_IMAGE_HEIGHT: lim_q.img_h_m1  <= img_m1(data);
				REG_TILE_WIDTH:   lim_q.tile_w_m1 <= tile_m1(data);
				REG_TILE_HEIGHT:  lim_q.tile_h_m1 <= tile_m1(data);
				default: ;
			endcase
		end
	end

	assign lim = lim_q;

endmodule

>>> src/tog_flag_mem.sv
module tog_flag_mem #(
	parameter int unsigned ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic              wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic              rdata
);

	localparam int unsigned DEPTH = 1 << ADDR_W;

	logic mem [DEPTH];
	logic rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read; pass a same-edge write through
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr))
				rdata_q <= wdata;
			else
				rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/tog_scan.sv
module tog_scan import tog_pkg::*; #(
	parameter int unsigned FREE_LEVEL    = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tog_limits_t        lim,
	input  logic               restart,
	input  logic               accept,
	input  logic [PIXEL_W-1:0] pixel,
	output logic               hit,
	output tog_result_t        res
);

	localparam logic [PIXEL_W-1:0] FREE_PIX = PIXEL_W'(FREE_LEVEL);

	logic [POS_W-1:0] pixel_x_q;
	logic [POS_W-1:0] pixel_y_q;
	logic [SUB_W-1:0] x_in_tile_q;
	logic [SUB_W-1:0] y_in_tile_q;
	logic [POS_W-1:0] tile_col_q;
	logic [POS_W-1:0] tile_row_q;
	logic             cur_free_q;

	logic              end_x_tile;
	logic              end_y_tile;
	logic              end_x_img;
	logic              end_y_img;
	logic              seg_end;
	logic              prev_free;
	logic              now_free;
	logic              row_flag;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] next_slot;
	logic [POS_W-1:0]  next_col;

	// position decode
	assign end_x_tile = (x_in_tile_q == lim.tile_w_m1);
	assign end_y_tile = (y_in_tile_q == lim.tile_h_m1);
	assign end_x_img  = (pixel_x_q >= lim.img_w_m1);
	assign end_y_img  = (pixel_y_q >= lim.img_h_m1);
	assign seg_end    = end_x_tile || end_x_img;

	// column slot of this pixel and of the next one
	assign next_col  = end_x_img ? '0 : (end_x_tile ? tile_col_q + 12'd1 : tile_col_q);
	assign slot      = tile_col_q[SLOT_W-1:0];
	assign next_slot = next_col[SLOT_W-1:0];

	// running free flag of this tile: reload on the tile's first pixel,
	// pick up the row above at the start of each later segment
	always_comb begin
		if (x_in_tile_q != '0)
			prev_free = cur_free_q;
		else if (y_in_tile_q == '0)
			prev_free = 1'b1;
		else
			prev_free = row_flag;
		now_free = prev_free && (pixel == FREE_PIX);
	end

	// per-column flags, read one pixel ahead
	tog_flag_mem #(
		.ADDR_W (SLOT_W)
	) u_flags (
		.clk   (clk),
		.we    (accept && seg_end),
		.waddr (slot),
		.wdata (now_free),
		.re    (accept),
		.raddr (next_slot),
		.rdata (row_flag)
	);

	// verdict at the tile's last pixel
	assign hit           = (end_x_tile || end_x_img) && (end_y_tile || end_y_img);
	assign res.tile_col  = tile_col_q;
	assign res.tile_row  = tile_row_q;
	assign res.passable  = end_x_tile && end_y_tile && now_free;
	assign res.last_tile = end_x_img && end_y_img;

	// advance the raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q   <= '0;
			pixel_y_q   <= '0;
			x_in_tile_q <= '0;
			y_in_tile_q <= '0;
			tile_col_q  <= '0;
			tile_row_q  <= '0;
			cur_free_q  <= 1'b1;
		end else if (restart) begin
			pixel_x_q   <= '0;
			pixel_y_q   <= '0;
			x_in_tile_q <= '0;
			y_in_tile_q <= '0;
			tile_col_q  <= '0;
			tile_row_q  <= '0;
		end else if (accept) begin
			cur_free_q <= now_free;
			if (end_x_img) begin
				pixel_x_q   <= '0;
				x_in_tile_q <= '0;
				tile_col_q  <= '0;
				if (end_y_img) begin
					pixel_y_q   <= '0;
					y_in_tile_q <= '0;
					tile_row_q  <= '0;
				end else begin
					pixel_y_q <= pixel_y_q + 12'd1;
					if (end_y_tile) begin
						y_in_tile_q <= '0;
						tile_row_q  <= tile_row_q + 12'd1;
					end else begin
						y_in_tile_q <= y_in_tile_q + 8'd1;
					end
				end
			end else begin
				pixel_x_q <= pixel_x_q + 12'd1;
				if (end_x_tile) begin
					x_in_tile_q <= '0;
					tile_col_q  <= tile_col_q + 12'd1;
				end else begin
					x_in_tile_q <= x_in_tile_q + 8'd1;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_x_in_tile_bound: assert property (@(posedge clk) disable iff (!arst_n)
		x_in_tile_q <= lim.tile_w_m1)
		else $error("x_in_tile beyond tile width");

	a_pixel_y_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_y_q <= lim.img_h_m1)
		else $error("pixel_y beyond image height");

	a_tile_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !restart && x_in_tile_q == '0 && y_in_tile_q == '0)
		|=> (cur_free_q == ($past(pixel) == FREE_PIX)))
		else $error("free flag not reloaded at tile start");

	a_last_tile_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !restart && hit && res.last_tile)
		|=> (pixel_x_q == '0 && pixel_y_q == '0 && tile_row_q == '0))
		else $error("raster did not wrap after last tile");
`endif

endmodule

>>> test/tile_obstacle_grid_tb.sv
`timescale 1ns / 1ps

module tile_obstacle_grid_tb;
	import tog_pkg::*;

	localparam int unsigned FREE_LEVEL    = 255;
	localparam int unsigned MAX_IMAGE     = 4096;
	localparam int unsigned MAX_TILE      = 256;
	localparam int unsigned DRAIN_CYCLES  = 4;
	localparam int unsigned REPORT_LIMIT  = 10;

	// indexes past the register list: they only restart the image
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 8'hFF;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;     // [7:0] pixel
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [31:0]            m_tdata;          // [11:0] tile_col, [23:12] tile_row, [24] passable
	logic                   m_tlast;          // last_tile

	tile_obstacle_grid u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// scan state mirrored from the block
	logic [12:0]      img_w_reg, img_h_reg;
	logic [8:0]       tile_w_reg, tile_h_reg;
	bit               col_free [MAX_TILE_COLS];
	logic [POS_W-1:0] scan_x, scan_y, tile_col_idx, tile_row_idx;
	logic [SUB_W-1:0] sub_x, sub_y;

	tog_result_t pending_verdicts [$];
	tog_result_t seen_tile, want_tile;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned err_count = 0;
	int unsigned n_pixels = 0;
	int unsigned n_tiles = 0;
	int unsigned n_passable = 0;
	int unsigned n_cfg_writes = 0;

	function automatic int unsigned clip_size(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void restart_scan();
		scan_x = '0;
		scan_y = '0;
		sub_x = '0;
		sub_y = '0;
		tile_col_idx = '0;
		tile_row_idx = '0;
	endfunction

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// fold one pixel into the tile flags and queue a verdict at a tile's last pixel
	function automatic void advance_tile_scan(input logic [7:0] pix);
		int unsigned w, h, tw, th;
		bit end_tx, end_ty, end_ix, end_iy;
		tog_result_t r;
		w = clip_size(img_w_reg, MAX_IMAGE);
		h = clip_size(img_h_reg, MAX_IMAGE);
		tw = clip_size(tile_w_reg, MAX_TILE);
		th = clip_size(tile_h_reg, MAX_TILE);
		end_tx = (sub_x == tw - 1);
		end_ty = (sub_y == th - 1);
		end_ix = (scan_x >= w - 1);
		end_iy = (scan_y >= h - 1);

		if (sub_x == 0 && sub_y == 0)
			col_free[tile_col_idx % MAX_TILE_COLS] = 1'b1;
		if (pix != FREE_LEVEL)
			col_free[tile_col_idx % MAX_TILE_COLS] = 1'b0;

		if ((end_tx || end_ix) && (end_ty || end_iy)) begin
			r.tile_col = tile_col_idx;
			r.tile_row = tile_row_idx;
			r.passable = end_tx && end_ty && col_free[tile_col_idx % MAX_TILE_COLS];
			r.last_tile = end_ix && end_iy;
			pending_verdicts.push_back(r);
		end

		if (end_ix) begin
			scan_x = '0;
			sub_x = '0;
			tile_col_idx = '0;
			if (end_iy) begin
				restart_scan();
			end else begin
				scan_y = scan_y + 1'b1;
				if (end_ty) begin
					sub_y = '0;
					tile_row_idx = tile_row_idx + 1'b1;
				end else begin
					sub_y = sub_y + 1'b1;
				end
			end
		end else begin
			scan_x = scan_x + 1'b1;
			if (end_tx) begin
				sub_x = '0;
				tile_col_idx = tile_col_idx + 1'b1;
			end else begin
				sub_x = sub_x + 1'b1;
			end
		end
	endfunction

	// random back-pressure on the tile stream
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	// compare every tile beat with the oldest pending verdict
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen_tile.tile_col = m_tdata[11:0];
			seen_tile.tile_row = m_tdata[23:12];
			seen_tile.passable = m_tdata[24];
			seen_tile.last_tile = m_tlast;
			n_tiles++;
			if (seen_tile.passable)
				n_passable++;
			if (pending_verdicts.size() == 0) begin
				note_error($sformatf("%0t: unexpected tile col %0d row %0d pass %0b last %0b",
					$realtime, seen_tile.tile_col, seen_tile.tile_row,
					seen_tile.passable, seen_tile.last_tile));
			end else begin
				want_tile = pending_verdicts.pop_front();
				if (want_tile != seen_tile)
					note_error($sformatf(
						"%0t: tile mismatch exp col %0d row %0d pass %0b last %0b, got col %0d row %0d pass %0b last %0b",
						$realtime, want_tile.tile_col, want_tile.tile_row,
						want_tile.passable, want_tile.last_tile, seen_tile.tile_col,
						seen_tile.tile_row, seen_tile.passable, seen_tile.last_tile));
			end
		end
	end

	// send one pixel beat after a random gap; valid stays up for the next call
	task automatic send_pixel(input logic [7:0] pix);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_tile_scan(pix);
		n_pixels++;
	endtask

	// drop valid and let every pending verdict come out
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  img_w_reg = val;
			REG_IMAGE_HEIGHT: img_h_reg = val;
			REG_TILE_WIDTH:   tile_w_reg = val[8:0];
			REG_TILE_HEIGHT:  tile_h_reg = val[8:0];
			default:          ;
		endcase
		restart_scan();
		n_cfg_writes++;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [12:0] w, input logic [12:0] h,
			input logic [12:0] tw, input logic [12:0] th);
		wait_drain();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_TILE_WIDTH, tw);
		write_reg(REG_TILE_HEIGHT, th);
	endtask

	function automatic logic [7:0] map_pixel(input int unsigned noise_pct);
		if ($urandom_range(99) < noise_pct)
			return 8'($urandom_range(0, FREE_LEVEL - 1));
		return 8'(FREE_LEVEL);
	endfunction

	// reset geometry 640x480 with 16x16 tiles: no verdict early in the first
	// tile row, then tile height cut to one so the reset widths show up
	task automatic test_reset_geometry();
		repeat (200)
			send_pixel(($urandom_range(199) == 0) ? 8'($urandom_range(0, 254)) : 8'(FREE_LEVEL));
		wait_drain();
		write_reg(REG_TILE_HEIGHT, 13'd1);
		repeat (640)
			send_pixel(($urandom_range(199) == 0) ? 8'($urandom_range(0, 254)) : 8'(FREE_LEVEL));
	endtask

	// hand-picked pixels: free and blocked full tiles, partial edges, tiny sizes
	task automatic test_directed();
		logic [7:0] grid [15];
		grid = '{8'd255, 8'd255, 8'd0,   8'd255, 8'd255,
		         8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		         8'd255, 8'd128, 8'd127, 8'd254, 8'd255};
		set_geometry(13'd5, 13'd3, 13'd2, 13'd2);
		foreach (grid[i])
			send_pixel(grid[i]);
		// zero sizes act as one: a one-pixel image
		set_geometry(13'd0, 13'd0, 13'd0, 13'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		// tile larger than the image: one partial tile
		set_geometry(13'd3, 13'd2, 13'd300, 13'd9);
		repeat (6) send_pixel(8'd255);
	endtask

	// oversized image and tile values cap, tile sizes keep only nine bits
	task automatic test_size_limits();
		// 4097 wide acts as 4096, tile 257 as 256, tile height 513 as 1
		set_geometry(13'd4097, 13'd2, 13'd257, 13'd513);
		repeat (300) send_pixel(map_pixel(0));
		// one pixel wide, all-ones height acts as 4096, tile height 257 as 256
		set_geometry(13'd1, 13'h1FFF, 13'd1, 13'd257);
		repeat (300) send_pixel(map_pixel(1));
	endtask

	// small random maps, some cut short by a write to a spare index
	task automatic test_random_maps(input int unsigned budget);
		int unsigned sent, w, h, tw, th, area, noise, cut;
		int unsigned noise_levels [4];
		noise_levels = '{0, 1, 5, 30};
		sent = 0;
		while (sent < budget) begin
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 16);
			tw = ($urandom_range(9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, w + 2);
			th = ($urandom_range(9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, h + 2);
			noise = noise_levels[$urandom_range(3)];
			area = w * h;
			set_geometry(13'(w), 13'(h), 13'(tw), 13'(th));
			if ($urandom_range(7) == 0) begin
				cut = $urandom_range(1, area);
				repeat (cut) send_pixel(map_pixel(noise));
				sent += cut;
				wait_drain();
				write_reg(8'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
					13'($urandom_range(0, 13'h1FFF)));
			end
			repeat (area) send_pixel(map_pixel(noise));
			sent += area;
		end
	endtask

	initial begin
		img_w_reg = 13'd640;
		img_h_reg = 13'd480;
		tile_w_reg = 9'd16;
		tile_h_reg = 9'd16;
		foreach (col_free[i])
			col_free[i] = 1'b1;
		restart_scan();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 36;
		rx_idle_pct = 70;
		test_reset_geometry();
		test_directed();
		test_random_maps(120);

		tx_idle_pct = 70;
		rx_idle_pct = 36;
		test_size_limits();
		test_random_maps(120);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_maps(120);

		wait_drain();
		repeat (8) @(posedge clk);
		if (pending_verdicts.size() != 0)
			note_error($sformatf("%0d tile verdicts never came out", pending_verdicts.size()));

		$display("covered %0d pixels and %0d tile verdicts (%0d passable), %0d register writes",
			n_pixels, n_tiles, n_passable, n_cfg_writes);
		$display("reset sizes, zero and oversized sizes, partial tiles, restarts; %0d errors",
			err_count);
		if (err_count == 0) begin
			$display("tile_obstacle_grid_tb: clean");
		end else begin
			$display("tile_obstacle_grid_tb: errors");
		end
		$finish;
	end

	// hard stop if the stream hangs
	initial begin
		#(64'd20_000_000);
		$display("timeout: %0d tile verdicts still pending", pending_verdicts.size());
		$display("tile_obstacle_grid_tb: errors");
		$finish;
	end

endmodule

>>> files.f
src/tog_pkg.sv
src/tog_cfg.sv
src/tog_flag_mem.sv
src/tog_scan.sv
src/tile_obstacle_grid.sv
test/tile_obstacle_grid_tb.sv
